### src/tgp_pkg.sv
// ----------------------------------------------------------------------------
// tgp_pkg
// Shared types and codes for the turtle grid plotter.
// ----------------------------------------------------------------------------
`default_nettype none

package tgp_pkg;

   localparam int MODE_W     = 3;
   localparam int DIST_W     = 8;
   localparam int SEL_W      = 5;
   localparam int POS_W      = 5;
   localparam int HEADING_W  = 2;
   localparam int ROW_BITS_W = 20;

   localparam logic [MODE_W-1:0] MODE_PEN_UP   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PEN_DOWN = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RIGHT    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LEFT     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FORWARD  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ_ROW = 3'd5;

   localparam logic [HEADING_W-1:0] HEAD_EAST  = 2'd0;
   localparam logic [HEADING_W-1:0] HEAD_SOUTH = 2'd1;
   localparam logic [HEADING_W-1:0] HEAD_WEST  = 2'd2;
   localparam logic [HEADING_W-1:0] HEAD_NORTH = 2'd3;

   typedef struct packed {
      logic load;
      logic step;
      logic rd_row;
      logic mark;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_move;
      logic is_read;
      logic can_step;
      logic pen;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

### src/tgp_ram.sv
// ----------------------------------------------------------------------------
// tgp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tgp_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 20
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire                       rd_en,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/tgp_ctrl.sv
// ----------------------------------------------------------------------------
// tgp_ctrl
// Command sequencer: accepts a word, steps moves, marks cells, reads rows, hands off result.
// ----------------------------------------------------------------------------
`default_nettype none

module tgp_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  tgp_pkg::stat_type  stat,
   output tgp_pkg::cmd_type   cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_MARK = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_stall = reset || (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.is_move) begin
               if (stat.can_step) begin
                  cmd.step = 1'b1;
                  state_in = stat.pen ? S_MARK : S_EXEC;
               end else begin
                  state_in = S_DONE;
               end
            end else if (stat.is_read) begin
               cmd.rd_row = 1'b1;
               state_in   = S_DONE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            state_in = S_EXEC;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### src/tgp_datapath.sv
// ----------------------------------------------------------------------------
// tgp_datapath
// Turtle state, floor memory with row valid flags, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tgp_datapath #(
   parameter int GRID_SIZE = 20
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  tgp_pkg::cmd_type                        cmd,
   output tgp_pkg::stat_type                       stat,
   input  wire [tgp_pkg::MODE_W-1:0]               req_mode,
   input  wire [tgp_pkg::DIST_W-1:0]               req_distance,
   input  wire [tgp_pkg::SEL_W-1:0]                req_row_select,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output logic [tgp_pkg::POS_W-1:0]               rsp_pos_row,
   output logic [tgp_pkg::POS_W-1:0]               rsp_pos_col,
   output logic [tgp_pkg::HEADING_W-1:0]           rsp_heading_out,
   output logic                                    rsp_pen_down,
   output logic [tgp_pkg::ROW_BITS_W-1:0]          rsp_row_bits
);

   localparam int RW  = $clog2(GRID_SIZE);
   localparam int SW  = (RW > tgp_pkg::SEL_W) ? RW : tgp_pkg::SEL_W;
   localparam int PW  = (RW > tgp_pkg::POS_W) ? RW : tgp_pkg::POS_W;
   localparam int RBW = (GRID_SIZE > tgp_pkg::ROW_BITS_W) ? GRID_SIZE : tgp_pkg::ROW_BITS_W;
   localparam logic [RW-1:0] LAST = RW'(GRID_SIZE - 1);

   logic [tgp_pkg::MODE_W-1:0]    mode_ff;
   logic [tgp_pkg::DIST_W-1:0]    dist_ff, dist_in;
   logic                          sel_ok_ff;
   logic [RW-1:0]                 sel_addr_ff;
   logic [RW-1:0]                 cur_row_ff, cur_row_in;
   logic [RW-1:0]                 cur_col_ff, cur_col_in;
   logic [tgp_pkg::HEADING_W-1:0] heading_ff, heading_in;
   logic                          pen_ff, pen_in;
   logic [GRID_SIZE-1:0]          valid_ff;
   logic                          rd_valid_ff;

   logic                          rsp_valid_ff;
   logic [tgp_pkg::POS_W-1:0]     pos_row_ff, pos_col_ff;
   logic [tgp_pkg::HEADING_W-1:0] heading_out_ff;
   logic                          pen_down_ff;
   logic [tgp_pkg::ROW_BITS_W-1:0] row_bits_ff, row_bits_in;

   logic [SW:0]                   sel_ext;
   logic [RW-1:0]                 next_row, next_col;
   logic                          edge_ok;
   logic                          rd_en;
   logic [RW-1:0]                 rd_addr;
   logic [GRID_SIZE-1:0]          rd_data;
   logic [GRID_SIZE-1:0]          wr_data;
   logic [RBW-1:0]                row_ext;
   logic [PW-1:0]                 row_pos_ext, col_pos_ext;

   assign sel_ext = (SW + 1)'(req_row_select);

   // next cell in the current heading
   always_comb begin
      next_row = cur_row_ff;
      next_col = cur_col_ff;
      edge_ok  = 1'b0;
      case (heading_ff)
         tgp_pkg::HEAD_EAST: begin
            edge_ok  = (cur_col_ff != LAST);
            next_col = cur_col_ff + RW'(1);
         end
         tgp_pkg::HEAD_SOUTH: begin
            edge_ok  = (cur_row_ff != LAST);
            next_row = cur_row_ff + RW'(1);
         end
         tgp_pkg::HEAD_WEST: begin
            edge_ok  = (cur_col_ff != '0);
            next_col = cur_col_ff - RW'(1);
         end
         tgp_pkg::HEAD_NORTH: begin
            edge_ok  = (cur_row_ff != '0);
            next_row = cur_row_ff - RW'(1);
         end
         default: begin
            edge_ok = 1'b0;
         end
      endcase
   end

   assign stat.is_move  = (mode_ff == tgp_pkg::MODE_FORWARD);
   assign stat.is_read  = (mode_ff == tgp_pkg::MODE_READ_ROW);
   assign stat.can_step = (dist_ff != '0) && edge_ok;
   assign stat.pen      = pen_ff;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   // pen and turns take effect when the word is taken
   always_comb begin
      pen_in     = pen_ff;
      heading_in = heading_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      dist_in    = dist_ff;
      if (cmd.load) begin
         dist_in = req_distance;
         case (req_mode)
            tgp_pkg::MODE_PEN_UP:   pen_in = 1'b0;
            tgp_pkg::MODE_PEN_DOWN: pen_in = 1'b1;
            tgp_pkg::MODE_RIGHT:    heading_in = heading_ff + 2'd1;
            tgp_pkg::MODE_LEFT:     heading_in = heading_ff - 2'd1;
            default: begin
               pen_in = pen_ff;
            end
         endcase
      end
      if (cmd.step) begin
         cur_row_in = next_row;
         cur_col_in = next_col;
         dist_in    = dist_ff - tgp_pkg::DIST_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         heading_ff <= tgp_pkg::HEAD_EAST;
         pen_ff     <= 1'b0;
         valid_ff   <= '0;
         mode_ff    <= tgp_pkg::MODE_PEN_UP;
      end else begin
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         heading_ff <= heading_in;
         pen_ff     <= pen_in;
         if (cmd.load) begin
            mode_ff <= req_mode;
         end
         if (cmd.mark) begin
            valid_ff[cur_row_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      if (cmd.load) begin
         sel_ok_ff   <= (sel_ext < (SW + 1)'(GRID_SIZE));
         sel_addr_ff <= sel_ext[RW-1:0];
      end
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // floor memory, read-modify-write per marked cell
   assign rd_en   = cmd.step || cmd.rd_row;
   assign rd_addr = cmd.rd_row ? sel_addr_ff : next_row;
   assign wr_data = (rd_valid_ff ? rd_data : '0) | (GRID_SIZE'(1) << cur_col_ff);

   tgp_ram #(
      .WIDTH (GRID_SIZE),
      .DEPTH (GRID_SIZE)
   ) u_floor (
      .clock   (clock),
      .wr_en   (cmd.mark),
      .wr_addr (cur_row_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register
   assign row_ext     = RBW'(rd_data);
   assign row_pos_ext = PW'(cur_row_ff);
   assign col_pos_ext = PW'(cur_col_ff);

   always_comb begin
      row_bits_in = '0;
      if (stat.is_read && sel_ok_ff && rd_valid_ff) begin
         row_bits_in = row_ext[tgp_pkg::ROW_BITS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         pos_row_ff     <= row_pos_ext[tgp_pkg::POS_W-1:0];
         pos_col_ff     <= col_pos_ext[tgp_pkg::POS_W-1:0];
         heading_out_ff <= heading_ff;
         pen_down_ff    <= pen_ff;
         row_bits_ff    <= row_bits_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_row     = pos_row_ff;
   assign rsp_pos_col     = pos_col_ff;
   assign rsp_heading_out = heading_out_ff;
   assign rsp_pen_down    = pen_down_ff;
   assign rsp_row_bits    = row_bits_ff;

endmodule

`default_nettype wire

### src/turtle_grid_plotter_core.sv
// ----------------------------------------------------------------------------
// turtle_grid_plotter_core
// Turtle plotter on a GRID_SIZE x GRID_SIZE bit floor, one result per command.
// ----------------------------------------------------------------------------
// One command word is taken at a time and each returns one result word. Pen,
// turn and unused commands and row reads go from the execute state to the done
// state and then the result register; a forward move adds an execute step per
// cell entered with the pen up, or an execute and a mark step per cell entered
// with the pen down. Marking is a read-modify-write of one floor row through
// the floor RAM, whose registered read sets the per-cell cost. The floor is
// cleared at reset through per-row valid flags, so no clearing pass runs and
// the block takes words from the first cycle after reset. A result waiting on
// rsp_stall does not block the next command word from being taken.
`default_nettype none

module turtle_grid_plotter_core #(
   parameter int GRID_SIZE = 20
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire [tgp_pkg::MODE_W-1:0]            req_mode,
   input  wire [tgp_pkg::DIST_W-1:0]            req_distance,
   input  wire [tgp_pkg::SEL_W-1:0]             req_row_select,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [tgp_pkg::POS_W-1:0]            rsp_pos_row,
   output logic [tgp_pkg::POS_W-1:0]            rsp_pos_col,
   output logic [tgp_pkg::HEADING_W-1:0]        rsp_heading_out,
   output logic                                 rsp_pen_down,
   output logic [tgp_pkg::ROW_BITS_W-1:0]       rsp_row_bits
);

   tgp_pkg::cmd_type  cmd;
   tgp_pkg::stat_type stat;

   tgp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tgp_datapath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_mode),
      .req_distance    (req_distance),
      .req_row_select  (req_row_select),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_row     (rsp_pos_row),
      .rsp_pos_col     (rsp_pos_col),
      .rsp_heading_out (rsp_heading_out),
      .rsp_pen_down    (rsp_pen_down),
      .rsp_row_bits    (rsp_row_bits)
   );

endmodule

`default_nettype wire

### src/tgp_checker.sv
// ----------------------------------------------------------------------------
// tgp_checker
// Port-level checks for the turtle grid plotter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tgp_checker #(
   parameter int GRID_SIZE = 20
) (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_stall,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input wire [tgp_pkg::POS_W-1:0]         rsp_pos_row,
   input wire [tgp_pkg::POS_W-1:0]         rsp_pos_col
);

   // one word in flight: an accept closes the input side next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("word accepted while previous one still in flight");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((GRID_SIZE > 32) || (32'(rsp_pos_row) < GRID_SIZE)))
      else $error("row position off the floor");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((GRID_SIZE > 32) || (32'(rsp_pos_col) < GRID_SIZE)))
      else $error("column position off the floor");

endmodule

bind turtle_grid_plotter_core tgp_checker #(
   .GRID_SIZE (GRID_SIZE)
) u_tgp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_pos_row (rsp_pos_row),
   .rsp_pos_col (rsp_pos_col)
);

`default_nettype wire

### tb/sv/turtle_plot_checker.sv
// ----------------------------------------------------------------------------
// turtle_plot_checker
// Watches both channels of the turtle plotter, keeps its own copy of the
// turtle and the floor, and compares each result word with the oldest
// expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module turtle_plot_checker #(
   parameter int GRID_SIZE = 20
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   input  wire                                  req_stall,
   input  wire [tgp_pkg::MODE_W-1:0]            req_mode,
   input  wire [tgp_pkg::DIST_W-1:0]            req_distance,
   input  wire [tgp_pkg::SEL_W-1:0]             req_row_select,
   input  wire                                  rsp_valid,
   input  wire                                  rsp_stall,
   input  wire [tgp_pkg::POS_W-1:0]             rsp_pos_row,
   input  wire [tgp_pkg::POS_W-1:0]             rsp_pos_col,
   input  wire [tgp_pkg::HEADING_W-1:0]         rsp_heading_out,
   input  wire                                  rsp_pen_down,
   input  wire [tgp_pkg::ROW_BITS_W-1:0]        rsp_row_bits,
   output int                                   mismatch_count,
   output int                                   words_pending
);

   import tgp_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0]      pos_row;
      logic [POS_W-1:0]      pos_col;
      logic [HEADING_W-1:0]  heading;
      logic                  pen;
      logic [ROW_BITS_W-1:0] row_bits;
   } plot_word_t;

   int                   turtle_row;
   int                   turtle_col;
   logic [HEADING_W-1:0] turtle_heading;
   logic                 turtle_pen;
   logic [GRID_SIZE-1:0] floor_cells [GRID_SIZE];
   plot_word_t           expected_words [$];

   task automatic report_error(input string msg);
      $display("plot checker: %s", msg);
      mismatch_count++;
   endtask

   function automatic plot_word_t plot_command(input logic [MODE_W-1:0] mode,
                                               input logic [DIST_W-1:0] distance,
                                               input logic [SEL_W-1:0]  sel);
      plot_word_t res;
      logic       moved;
      res.row_bits = '0;
      case (mode)
         MODE_PEN_UP:   turtle_pen = 1'b0;
         MODE_PEN_DOWN: turtle_pen = 1'b1;
         MODE_RIGHT:    turtle_heading = turtle_heading + 2'd1;
         MODE_LEFT:     turtle_heading = turtle_heading - 2'd1;
         MODE_FORWARD: begin
            for (int n = 0; n < int'(distance); n++) begin
               moved = 1'b0;
               case (turtle_heading)
                  HEAD_EAST: if (turtle_col + 1 < GRID_SIZE) begin
                     turtle_col++;
                     moved = 1'b1;
                  end
                  HEAD_SOUTH: if (turtle_row + 1 < GRID_SIZE) begin
                     turtle_row++;
                     moved = 1'b1;
                  end
                  HEAD_WEST: if (turtle_col > 0) begin
                     turtle_col--;
                     moved = 1'b1;
                  end
                  default: if (turtle_row > 0) begin
                     turtle_row--;
                     moved = 1'b1;
                  end
               endcase
               if (!moved) break;
               if (turtle_pen) floor_cells[turtle_row][turtle_col] = 1'b1;
            end
         end
         MODE_READ_ROW: begin
            if (int'(sel) < GRID_SIZE) res.row_bits = ROW_BITS_W'(floor_cells[sel]);
         end
         default: ;
      endcase
      res.pos_row = POS_W'(turtle_row);
      res.pos_col = POS_W'(turtle_col);
      res.heading = turtle_heading;
      res.pen     = turtle_pen;
      return res;
   endfunction

   always @(posedge clock) begin
      plot_word_t want;
      int         delta;
      if (reset) begin
         turtle_row     = 0;
         turtle_col     = 0;
         turtle_heading = HEAD_EAST;
         turtle_pen     = 1'b0;
         for (int r = 0; r < GRID_SIZE; r++) floor_cells[r] = '0;
         expected_words.delete();
         words_pending <= 0;
      end else begin
         delta = 0;
         if (req_valid && !req_stall) begin
            expected_words.push_back(plot_command(req_mode, req_distance, req_row_select));
            delta++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_error($sformatf("result word with nothing expected: row %0d col %0d",
                                      rsp_pos_row, rsp_pos_col));
            end else begin
               want = expected_words.pop_front();
               delta--;
               if (rsp_pos_row !== want.pos_row)
                  report_error($sformatf("pos_row got %0d want %0d", rsp_pos_row, want.pos_row));
               if (rsp_pos_col !== want.pos_col)
                  report_error($sformatf("pos_col got %0d want %0d", rsp_pos_col, want.pos_col));
               if (rsp_heading_out !== want.heading)
                  report_error($sformatf("heading_out got %0d want %0d",
                                         rsp_heading_out, want.heading));
               if (rsp_pen_down !== want.pen)
                  report_error($sformatf("pen_down got %0b want %0b", rsp_pen_down, want.pen));
               if (rsp_row_bits !== want.row_bits)
                  report_error($sformatf("row_bits got %05h want %05h",
                                         rsp_row_bits, want.row_bits));
            end
         end
         words_pending <= words_pending + delta;
      end
   end

endmodule

`default_nettype wire

### tb/sv/turtle_grid_plotter_core_test.sv
// ----------------------------------------------------------------------------
// turtle_grid_plotter_core_test
// Drives command words into the turtle plotter with random gaps and result
// back-pressure: a directed walk around the floor edges, then weighted random
// commands. The checker beside the block predicts every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module turtle_grid_plotter_core_test;

   import tgp_pkg::*;

   localparam int GRID          = 20;
   localparam int RANDOM_WORDS  = 1880;
   localparam int CALM_WORDS    = 150;
   localparam int QUIET_LIMIT   = 1000;
   localparam int TAIL_CYCLES   = 60;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [MODE_W-1:0]     req_mode       = MODE_PEN_UP;
   logic [DIST_W-1:0]     req_distance   = '0;
   logic [SEL_W-1:0]      req_row_select = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [POS_W-1:0]      rsp_pos_row;
   logic [POS_W-1:0]      rsp_pos_col;
   logic [HEADING_W-1:0]  rsp_heading_out;
   logic                  rsp_pen_down;
   logic [ROW_BITS_W-1:0] rsp_row_bits;

   int   mismatch_count;
   int   words_pending;
   int   quiet_cycles    = 0;
   logic gaps_on         = 1'b1;
   logic calm            = 1'b0;

   turtle_grid_plotter_core #(.GRID_SIZE(GRID)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_distance    (req_distance),
      .req_row_select  (req_row_select),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_row     (rsp_pos_row),
      .rsp_pos_col     (rsp_pos_col),
      .rsp_heading_out (rsp_heading_out),
      .rsp_pen_down    (rsp_pen_down),
      .rsp_row_bits    (rsp_row_bits)
   );

   turtle_plot_checker #(.GRID_SIZE(GRID)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_distance    (req_distance),
      .req_row_select  (req_row_select),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_row     (rsp_pos_row),
      .rsp_pos_col     (rsp_pos_col),
      .rsp_heading_out (rsp_heading_out),
      .rsp_pen_down    (rsp_pen_down),
      .rsp_row_bits    (rsp_row_bits),
      .mismatch_count  (mismatch_count),
      .words_pending   (words_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // one command word, optionally after an idle burst
   task automatic send_command(input logic [MODE_W-1:0] mode,
                               input logic [DIST_W-1:0] distance,
                               input logic [SEL_W-1:0]  sel);
      if (gaps_on && !calm && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_distance   <= distance;
      req_row_select <= sel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // result back-pressure
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(100, 300)) @(posedge clock);
         else
            repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                pick;
      logic [MODE_W-1:0] mode;
      logic [DIST_W-1:0] distance;
      logic [SEL_W-1:0]  sel;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the edges with the pen down, then corner cases
      send_command(MODE_READ_ROW, 8'd0, 5'd0);
      send_command(MODE_PEN_DOWN, 8'd0, 5'd0);
      send_command(MODE_FORWARD, 8'd0, 5'd0);
      send_command(MODE_FORWARD, 8'd1, 5'd0);
      send_command(MODE_FORWARD, 8'd255, 5'd31);
      send_command(MODE_READ_ROW, 8'd255, 5'd0);
      send_command(MODE_RIGHT, 8'd0, 5'd0);
      send_command(MODE_FORWARD, 8'd255, 5'd0);
      send_command(MODE_RIGHT, 8'd0, 5'd0);
      send_command(MODE_FORWARD, 8'd255, 5'd0);
      send_command(MODE_READ_ROW, 8'd0, 5'd19);
      send_command(MODE_RIGHT, 8'd0, 5'd0);
      send_command(MODE_FORWARD, 8'd255, 5'd0);
      send_command(MODE_RIGHT, 8'd0, 5'd0);
      send_command(MODE_LEFT, 8'd0, 5'd0);
      send_command(MODE_LEFT, 8'd0, 5'd0);
      send_command(MODE_FORWARD, 8'd3, 5'd0);
      send_command(MODE_PEN_UP, 8'd255, 5'd31);
      send_command(MODE_LEFT, 8'd0, 5'd0);
      send_command(MODE_FORWARD, 8'd5, 5'd0);
      send_command(MODE_READ_ROW, 8'd0, 5'd20);
      send_command(MODE_READ_ROW, 8'd0, 5'd31);
      send_command(3'd6, 8'd255, 5'd31);
      send_command(3'd7, 8'd170, 5'd10);
      send_command(MODE_READ_ROW, 8'd85, 5'd5);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         if (i == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
         pick     = $urandom_range(0, 99);
         distance = DIST_W'($urandom_range(0, 255));
         sel      = SEL_W'($urandom_range(0, 31));
         if (pick < 35) begin
            mode = MODE_FORWARD;
            pick = $urandom_range(0, 99);
            if (pick < 60)      distance = DIST_W'($urandom_range(0, 6));
            else if (pick < 85) distance = DIST_W'($urandom_range(7, 25));
         end else if (pick < 55) begin
            mode = MODE_READ_ROW;
            if ($urandom_range(0, 6) != 0) sel = SEL_W'($urandom_range(0, GRID - 1));
         end else if (pick < 66) mode = MODE_RIGHT;
         else if (pick < 77)     mode = MODE_LEFT;
         else if (pick < 84)     mode = MODE_PEN_DOWN;
         else if (pick < 96)     mode = MODE_PEN_UP;
         else                    mode = MODE_W'($urandom_range(6, 7));
         send_command(mode, distance, sel);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
src/tgp_pkg.sv
src/tgp_ram.sv
src/tgp_ctrl.sv
src/tgp_datapath.sv
src/turtle_grid_plotter_core.sv
src/tgp_checker.sv
tb/sv/turtle_plot_checker.sv
tb/sv/turtle_grid_plotter_core_test.sv
